// ----- design/zsaf_pkg.sv -----
`default_nettype none
package zsaf_pkg;

   localparam int ENTRY_MAX  = 64;
   localparam int NAME_STORE = 4096;
   localparam int ENTRY_AW   = $clog2(ENTRY_MAX);
   localparam int NAME_AW    = $clog2(NAME_STORE);

   localparam logic [31:0] CRC_POLY  = 32'hedb88320;
   localparam logic [31:0] CRC_INIT  = 32'hffffffff;
   localparam logic [31:0] SIG_LOCAL = 32'h04034b50;
   localparam logic [31:0] SIG_CDIR  = 32'h02014b50;
   localparam logic [31:0] SIG_END   = 32'h06054b50;
   localparam logic [7:0]  ZIP_VER   = 8'd20;

   localparam logic [1:0] OP_NAME  = 2'd0;
   localparam logic [1:0] OP_DATA  = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   localparam logic [2:0] ERR_OK       = 3'd0;
   localparam logic [2:0] ERR_NO_NAME  = 3'd1;
   localparam logic [2:0] ERR_NAME_FULL= 3'd2;
   localparam logic [2:0] ERR_RANGE    = 3'd3;
   localparam logic [2:0] ERR_ENTRIES  = 3'd4;
   localparam logic [2:0] ERR_EMPTY    = 3'd5;
   localparam logic [2:0] ERR_ORDER    = 3'd6;

   localparam logic [4:0] HDR_RESULTS   = 5'd31;
   localparam logic [4:0] PATCH_RESULTS = 5'd14;

   typedef enum logic [1:0] {
      CMD_ERR,
      CMD_BYTE,
      CMD_HDR,
      CMD_PATCH
   } cmd_kind_type;

   // One queued command; each expands to one or more output transactions.
   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  addr;
      logic [7:0]   value;
      logic         done;
      logic [2:0]   error;
      logic [31:0]  crc;
      logic [31:0]  size;
      logic [15:0]  name_len;
   } cmd_type;

   function automatic logic [7:0] le_byte(input logic [31:0] v, input logic [1:0] k);
      le_byte = v[{k, 3'b000} +: 8];
   endfunction

   // Reflected CRC-32 table entry.
   function automatic logic [31:0] crc_entry(input logic [7:0] idx);
      logic [31:0] c;
      c = {24'd0, idx};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      crc_entry = c;
   endfunction

endpackage
`default_nettype wire

// ----- design/zsaf_queue.sv -----
`default_nettype none
module zsaf_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   wr_en,
   input  zsaf_pkg::cmd_type     wr_data,
   output logic                  q_full,
   input  wire                   rd_en,
   output zsaf_pkg::cmd_type     rd_data,
   output logic                  q_empty
);
   import zsaf_pkg::*;

   cmd_type    slot_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {2'd0, wr_en} - {2'd0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = slot_ff[rd_ptr_ff];
   assign q_full  = count_ff[2];
   assign q_empty = (count_ff == 3'd0);

endmodule
`default_nettype wire

// ----- design/zsaf_front.sv -----
`default_nettype none
module zsaf_front (
   input  wire                clock,
   input  wire                reset,
   input  wire                accept,
   input  wire  [1:0]         op,
   input  wire  [7:0]         byte_in,
   output logic               cmd_valid,
   output zsaf_pkg::cmd_type  cmd
);
   import zsaf_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE, PH_NAME, PH_DATA, PH_TRAILER, PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [32:0] wo_ff, wo_in;
   logic [31:0] hdr_off_ff, hdr_off_in;
   logic [31:0] crc_ff, crc_in;
   logic [32:0] esize_ff, esize_in;
   logic [12:0] nlen_ff, nlen_in;
   logic [12:0] fill_ff, fill_in;
   logic [6:0]  count_ff, count_in;
   logic [6:0]  rec_ff, rec_in;
   logic [12:0] tbyte_ff, tbyte_in;
   logic [31:0] dstart_ff, dstart_in;
   logic [12:0] nptr_ff, nptr_in;

   logic [7:0]  name_mem [NAME_STORE];
   logic [31:0] dcrc_mem  [ENTRY_MAX];
   logic [31:0] dsize_mem [ENTRY_MAX];
   logic [31:0] doff_mem  [ENTRY_MAX];
   logic [12:0] dlen_mem  [ENTRY_MAX];
   logic [7:0]  name_q;
   logic [31:0] dcrc_q, dsize_q, doff_q;
   logic [12:0] dlen_q;

   logic        name_we, dir_we;
   logic [2:0]  err;
   logic [7:0]  tval;
   logic        tdone;
   logic [12:0] b;
   logic [31:0] dsz;
   logic [13:0] rec_end;

   always_comb begin
      phase_in   = phase_ff;
      wo_in      = wo_ff;
      hdr_off_in = hdr_off_ff;
      crc_in     = crc_ff;
      esize_in   = esize_ff;
      nlen_in    = nlen_ff;
      fill_in    = fill_ff;
      count_in   = count_ff;
      rec_in     = rec_ff;
      tbyte_in   = tbyte_ff;
      dstart_in  = dstart_ff;
      nptr_in    = nptr_ff;
      name_we    = 1'b0;
      dir_we     = 1'b0;
      err        = ERR_OK;
      tval       = '0;
      tdone      = 1'b0;
      b          = '0;
      dsz        = '0;
      rec_end    = '0;
      cmd          = '0;
      cmd.kind     = CMD_BYTE;
      cmd.addr     = wo_ff[31:0];
      cmd.value    = byte_in;

      unique case (op)
         OP_NAME: begin
            if (phase_ff == PH_IDLE) begin
               if (count_ff >= 7'(ENTRY_MAX))           err = ERR_ENTRIES;
               else if (fill_ff >= 13'(NAME_STORE))     err = ERR_NAME_FULL;
               else if (wo_ff > 33'h0_FFFF_FFE1)        err = ERR_RANGE;
            end else if (phase_ff == PH_NAME) begin
               if (fill_ff >= 13'(NAME_STORE))          err = ERR_NAME_FULL;
               else if ({3'd0, nlen_ff} >= 16'hffff || wo_ff[32]) err = ERR_RANGE;
            end else begin
               err = ERR_ORDER;
            end
            if (err == ERR_OK) begin
               name_we = 1'b1;
               fill_in = fill_ff + 13'd1;
               if (phase_ff == PH_IDLE) begin
                  cmd.kind   = CMD_HDR;
                  hdr_off_in = wo_ff[31:0];
                  wo_in      = wo_ff + 33'd31;
                  crc_in     = CRC_INIT;
                  esize_in   = '0;
                  nlen_in    = 13'd1;
                  phase_in   = PH_NAME;
               end else begin
                  wo_in   = wo_ff + 33'd1;
                  nlen_in = nlen_ff + 13'd1;
               end
            end
         end
         OP_DATA: begin
            if (phase_ff == PH_IDLE)                               err = ERR_NO_NAME;
            else if (phase_ff != PH_NAME && phase_ff != PH_DATA)   err = ERR_ORDER;
            else if (esize_ff >= 33'h0_FFFF_FFFF || wo_ff[32])     err = ERR_RANGE;
            if (err == ERR_OK) begin
               phase_in = PH_DATA;
               crc_in   = (crc_ff >> 8) ^ crc_entry(crc_ff[7:0] ^ byte_in);
               esize_in = esize_ff + 33'd1;
               wo_in    = wo_ff + 33'd1;
            end
         end
         OP_END: begin
            if (phase_ff == PH_IDLE)                               err = ERR_NO_NAME;
            else if (phase_ff != PH_NAME && phase_ff != PH_DATA)   err = ERR_ORDER;
            if (err == ERR_OK) begin
               cmd.kind     = CMD_PATCH;
               cmd.addr     = hdr_off_ff;
               cmd.crc      = crc_ff ^ CRC_INIT;
               cmd.size     = esize_ff[31:0];
               cmd.name_len = {3'd0, nlen_ff};
               dir_we       = (count_ff < 7'(ENTRY_MAX));
               if (dir_we) count_in = count_ff + 7'd1;
               crc_in   = CRC_INIT;
               esize_in = '0;
               nlen_in  = '0;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            if (phase_ff == PH_IDLE) begin
               if (count_ff == 7'd0)    err = ERR_EMPTY;
               else if (wo_ff[32])      err = ERR_RANGE;
            end else if (phase_ff != PH_TRAILER) begin
               err = ERR_ORDER;
            end else if (wo_ff[32]) begin
               err = ERR_RANGE;
            end
            if (err == ERR_OK) begin
               // Starting the trailer: record 0, byte 0, name pointer 0.
               if (phase_ff == PH_IDLE) begin
                  b         = '0;
                  dstart_in = wo_ff[31:0];
                  rec_in    = '0;
                  nptr_in   = '0;
                  phase_in  = PH_TRAILER;
               end else begin
                  b = tbyte_ff;
               end
               if (rec_in < count_ff && rec_in < 7'(ENTRY_MAX)) begin
                  priority if (b < 13'd4)                   tval = le_byte(SIG_CDIR, b[1:0]);
                  else if (b == 13'd4 || b == 13'd6)        tval = ZIP_VER;
                  else if (b >= 13'd16 && b < 13'd20)       tval = le_byte(dcrc_q, b[1:0]);
                  else if (b >= 13'd20 && b < 13'd28)       tval = le_byte(dsize_q, b[1:0]);
                  else if (b == 13'd28 || b == 13'd29)      tval = le_byte({19'd0, dlen_q}, b[1:0]);
                  else if (b >= 13'd42 && b < 13'd46)       tval = le_byte(doff_q, b[1:0] - 2'd2);
                  else if (b >= 13'd46)                     tval = name_q;
                  else                                      tval = '0;
                  if (b >= 13'd46) nptr_in = nptr_in + 13'd1;
                  rec_end = {1'b0, dlen_q} + 14'd46;
                  if ({1'b0, b} + 14'd1 >= rec_end) begin
                     rec_in   = rec_in + 7'd1;
                     tbyte_in = '0;
                  end else begin
                     tbyte_in = b + 13'd1;
                  end
               end else begin
                  dsz = wo_ff[31:0] - {19'd0, b} - dstart_ff;
                  priority if (b < 13'd4)                   tval = le_byte(SIG_END, b[1:0]);
                  else if (b >= 13'd8 && b < 13'd12)        tval = b[0] ? 8'd0 : {1'b0, count_ff};
                  else if (b >= 13'd12 && b < 13'd16)       tval = le_byte(dsz, b[1:0]);
                  else if (b >= 13'd16 && b < 13'd20)       tval = le_byte(dstart_in, b[1:0]);
                  else                                      tval = '0;
                  tbyte_in = b + 13'd1;
                  if (b + 13'd1 >= 13'd22) begin
                     phase_in = PH_DONE;
                     tdone    = 1'b1;
                  end
               end
               cmd.value = tval;
               cmd.done  = tdone;
               wo_in     = wo_ff + 33'd1;
            end
         end
      endcase

      if (err != ERR_OK) begin
         cmd       = '0;
         cmd.kind  = CMD_ERR;
         cmd.error = err;
      end
   end

   assign cmd_valid = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         wo_ff      <= '0;
         hdr_off_ff <= '0;
         crc_ff     <= CRC_INIT;
         esize_ff   <= '0;
         nlen_ff    <= '0;
         fill_ff    <= '0;
         count_ff   <= '0;
         rec_ff     <= '0;
         tbyte_ff   <= '0;
         dstart_ff  <= '0;
         nptr_ff    <= '0;
      end else if (accept && err == ERR_OK) begin
         phase_ff   <= phase_in;
         wo_ff      <= wo_in;
         hdr_off_ff <= hdr_off_in;
         crc_ff     <= crc_in;
         esize_ff   <= esize_in;
         nlen_ff    <= nlen_in;
         fill_ff    <= fill_in;
         count_ff   <= count_in;
         rec_ff     <= rec_in;
         tbyte_ff   <= tbyte_in;
         dstart_ff  <= dstart_in;
         nptr_ff    <= nptr_in;
      end
   end

   // Name store: written in order, read ahead at the next trailer name pointer.
   logic [12:0] nptr_rd;
   logic [6:0]  rec_rd;
   assign nptr_rd = (accept && err == ERR_OK) ? nptr_in : nptr_ff;
   assign rec_rd  = (accept && err == ERR_OK) ? rec_in  : rec_ff;

   always_ff @(posedge clock) begin
      if (accept && name_we) begin
         name_mem[fill_ff[NAME_AW-1:0]] <= byte_in;
      end
      name_q <= name_mem[nptr_rd[NAME_AW-1:0]];
   end

   // Directory rows, read ahead at the current trailer record with write bypass.
   always_ff @(posedge clock) begin
      if (accept && dir_we) begin
         dcrc_mem[count_ff[ENTRY_AW-1:0]]  <= cmd.crc;
         dsize_mem[count_ff[ENTRY_AW-1:0]] <= cmd.size;
         doff_mem[count_ff[ENTRY_AW-1:0]]  <= hdr_off_ff;
         dlen_mem[count_ff[ENTRY_AW-1:0]]  <= nlen_ff;
      end
      if (accept && dir_we && count_ff[ENTRY_AW-1:0] == rec_rd[ENTRY_AW-1:0]) begin
         dcrc_q  <= cmd.crc;
         dsize_q <= cmd.size;
         doff_q  <= hdr_off_ff;
         dlen_q  <= nlen_ff;
      end else begin
         dcrc_q  <= dcrc_mem[rec_rd[ENTRY_AW-1:0]];
         dsize_q <= dsize_mem[rec_rd[ENTRY_AW-1:0]];
         doff_q  <= doff_mem[rec_rd[ENTRY_AW-1:0]];
         dlen_q  <= dlen_mem[rec_rd[ENTRY_AW-1:0]];
      end
   end

endmodule
`default_nettype wire

// ----- design/zsaf_back.sv -----
`default_nettype none
module zsaf_back (
   input  wire                clock,
   input  wire                reset,
   input  wire                q_empty,
   input  zsaf_pkg::cmd_type  head,
   output logic               q_pop,
   input  wire                pop,
   output logic               empty,
   output logic               write_enable,
   output logic [31:0]        address,
   output logic [7:0]         value,
   output logic               last,
   output logic [2:0]         error,
   output logic               archive_done
);
   import zsaf_pkg::*;

   logic [4:0]  idx_ff, idx_in;
   logic        ov_ff, ov_in;
   logic        we_ff, we_in;
   logic [31:0] addr_ff, addr_in;
   logic [7:0]  val_ff, val_in;
   logic        last_ff, last_in;
   logic [2:0]  err_ff, err_in;
   logic        done_ff, done_in;
   logic        advance;
   logic [4:0]  pidx;

   assign advance = !q_empty && (!ov_ff || pop);

   always_comb begin
      we_in   = 1'b1;
      addr_in = head.addr;
      val_in  = head.value;
      last_in = 1'b1;
      err_in  = ERR_OK;
      done_in = 1'b0;
      pidx    = '0;
      unique case (head.kind)
         CMD_ERR: begin
            we_in   = 1'b0;
            addr_in = '0;
            val_in  = '0;
            err_in  = head.error;
         end
         CMD_BYTE: begin
            done_in = head.done;
         end
         CMD_HDR: begin
            addr_in = head.addr + {27'd0, idx_ff};
            last_in = (idx_ff == HDR_RESULTS - 5'd1);
            priority if (idx_ff < 5'd4)   val_in = le_byte(SIG_LOCAL, idx_ff[1:0]);
            else if (idx_ff == 5'd4)      val_in = ZIP_VER;
            else if (last_in)             val_in = head.value;
            else                          val_in = '0;
         end
         default: begin
            addr_in = head.addr + 32'd14 + {27'd0, idx_ff};
            last_in = (idx_ff == PATCH_RESULTS - 5'd1);
            pidx    = idx_ff - 5'd4;
            priority if (idx_ff < 5'd4)   val_in = le_byte(head.crc, idx_ff[1:0]);
            else if (idx_ff < 5'd12)      val_in = le_byte(head.size, pidx[1:0]);
            else                          val_in = le_byte({16'd0, head.name_len}, idx_ff[1:0]);
         end
      endcase
      idx_in = (advance && !last_in) ? idx_ff + 5'd1 : (advance ? 5'd0 : idx_ff);
      ov_in  = advance ? 1'b1 : (pop ? 1'b0 : ov_ff);
   end

   assign q_pop = advance && last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         ov_ff  <= ov_in;
      end
      if (advance) begin
         we_ff   <= we_in;
         addr_ff <= addr_in;
         val_ff  <= val_in;
         last_ff <= last_in;
         err_ff  <= err_in;
         done_ff <= done_in;
      end
   end

   assign empty        = !ov_ff;
   assign write_enable = we_ff;
   assign address      = addr_ff;
   assign value        = val_ff;
   assign last         = last_ff;
   assign error        = err_ff;
   assign archive_done = done_ff;

endmodule
`default_nettype wire

// ----- design/zip_stored_archive_framer.sv -----
// An accepted transaction passes through the command queue and the output register.
// Throughput: one input transaction per cycle while each yields one result and pop is high;
// the port moves one byte per cycle; a first name byte makes 31 writes, an end of entry 14.
// A four-entry command queue lets the input side run ahead of the result side.
// Reset (synchronous, active high) clears all control state directly; no clearing pass.
`default_nettype none
module zip_stored_archive_framer (
   input  wire         clock,
   input  wire         reset,
   input  wire         push,
   output logic        full,
   input  wire  [1:0]  req_op,
   input  wire  [7:0]  req_byte_in,
   output logic        empty,
   input  wire         pop,
   output logic        rsp_write_enable,
   output logic [31:0] rsp_address,
   output logic [7:0]  rsp_value,
   output logic        rsp_last,
   output logic [2:0]  rsp_error,
   output logic        rsp_archive_done
);
   import zsaf_pkg::*;

   // The front end validates each transaction, keeps all archive state and
   // the name and directory stores, and emits one command per transaction.
   logic    cmd_valid;
   cmd_type cmd;
   logic    q_full, q_empty, q_pop;
   cmd_type head;

   assign full = q_full;

   zsaf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (push && !q_full),
      .op        (req_op),
      .byte_in   (req_byte_in),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   zsaf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_valid),
      .wr_data (cmd),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_data (head),
      .q_empty (q_empty)
   );

   // The back end expands each command into byte writes or an error result through a register.
   zsaf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .head         (head),
      .q_pop        (q_pop),
      .pop          (pop),
      .empty        (empty),
      .write_enable (rsp_write_enable),
      .address      (rsp_address),
      .value        (rsp_value),
      .last         (rsp_last),
      .error        (rsp_error),
      .archive_done (rsp_archive_done)
   );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for zip_stored_archive_framer.
// A behavioral predictor runs alongside the design and keeps its own copy of the
// archive state. Every accepted input transaction is expanded into the byte writes
// it should cause, and a monitor compares each accepted output transaction with
// the oldest expected write, field by field. Because the design resets only once,
// the tests build one archive together: the error cases first, then a few random
// entries, and finally the trailer.
module tb;
   import zsaf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NAME,
      ST_DATA,
      ST_TRAILER,
      ST_DONE
   } arc_state_type;

   // One expected output transaction.
   typedef struct packed {
      logic        we;
      logic [31:0] addr;
      logic [7:0]  value;
      logic        last;
      logic [2:0]  error;
      logic        done;
   } arc_write_type;

   localparam int STALL_LIMIT    = 3000;
   // The trailer costs one transaction per directory byte, so the random phase
   // keeps the archive small.
   localparam int RANDOM_ITEMS   = 150;
   localparam int RANDOM_ENTRIES = 3;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [1:0]  req_op;
   logic [7:0]  req_byte_in;
   logic        empty;
   logic        pop;
   logic        rsp_write_enable;
   logic [31:0] rsp_address;
   logic [7:0]  rsp_value;
   logic        rsp_last;
   logic [2:0]  rsp_error;
   logic        rsp_archive_done;

   zip_stored_archive_framer u_top (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_op           (req_op),
      .req_byte_in      (req_byte_in),
      .empty            (empty),
      .pop              (pop),
      .rsp_write_enable (rsp_write_enable),
      .rsp_address      (rsp_address),
      .rsp_value        (rsp_value),
      .rsp_last         (rsp_last),
      .rsp_error        (rsp_error),
      .rsp_archive_done (rsp_archive_done)
   );

   // Shadow copy of the archive state, advanced once per accepted transaction.
   arc_state_type arc_state;
   logic [32:0]   wr_offset;
   logic [31:0]   hdr_offset;
   logic [31:0]   crc_acc;
   logic [32:0]   data_count;
   logic [12:0]   name_len;
   logic [12:0]   name_fill;
   logic [7:0]    name_mem [NAME_STORE];
   logic [31:0]   row_crc [ENTRY_MAX];
   logic [31:0]   row_size [ENTRY_MAX];
   logic [31:0]   row_offset [ENTRY_MAX];
   logic [12:0]   row_name_start [ENTRY_MAX];
   logic [12:0]   row_name_len [ENTRY_MAX];
   logic [6:0]    entries;
   logic [6:0]    tr_row;
   logic [12:0]   tr_byte;
   logic [31:0]   cdir_start;

   arc_write_type expected_writes[$];
   int            error_count;
   int            sender_idle_pct;
   int            receiver_stall_pct;
   int            idle_cycles;
   int            random_items;

   always #5 clock = ~clock;

   // Byte-wise reflected CRC-32 update, computed bit by bit.
   function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         x = x[0] ? ((x >> 1) ^ 32'hedb88320) : (x >> 1);
      end
      return x;
   endfunction

   function automatic logic [7:0] byte_of(input logic [31:0] v, input int k);
      return v[8 * (k % 4) +: 8];
   endfunction

   function automatic void add_write(ref arc_write_type q[$], input logic [32:0] addr,
                                     input logic [7:0] value, input logic done);
      arc_write_type w;
      w = '{we: 1'b1, addr: addr[31:0], value: value, last: 1'b0, error: ERR_OK, done: done};
      q.insert(q.size(), w);
   endfunction

   function automatic void add_reject(input logic [2:0] code);
      arc_write_type w;
      w = '{we: 1'b0, addr: 32'd0, value: 8'd0, last: 1'b1, error: code, done: 1'b0};
      expected_writes.insert(expected_writes.size(), w);
   endfunction

   // Byte b of central directory row r.
   function automatic logic [7:0] cdir_byte(input int r, input int b);
      int idx;
      if (b < 4) return byte_of(SIG_CDIR, b);
      if (b == 4 || b == 6) return ZIP_VER;
      if (b >= 16 && b < 20) return byte_of(row_crc[r], b - 16);
      if (b >= 20 && b < 28) return byte_of(row_size[r], b);
      if (b == 28 || b == 29) return byte_of({19'd0, row_name_len[r]}, b - 28);
      if (b >= 42 && b < 46) return byte_of(row_offset[r], b - 42);
      if (b >= 46) begin
         idx = row_name_start[r] + (b - 46);
         return idx < NAME_STORE ? name_mem[idx] : 8'd0;
      end
      return 8'd0;
   endfunction

   // Byte b of the end of central directory record.
   function automatic logic [7:0] eocd_byte(input int b);
      logic [31:0] dir_bytes;
      dir_bytes = wr_offset[31:0] - {19'd0, tr_byte} - cdir_start;
      if (b < 4) return byte_of(SIG_END, b);
      if (b >= 8 && b < 12) return byte_of({25'd0, entries}, b % 2);
      if (b >= 12 && b < 16) return byte_of(dir_bytes, b - 12);
      if (b >= 16 && b < 20) return byte_of(cdir_start, b - 16);
      return 8'd0;
   endfunction

   // Expands one accepted transaction into its expected writes and advances the
   // shadow state. Rejected transactions leave the state untouched.
   function automatic void predict_archive(input logic [1:0] op, input logic [7:0] b);
      arc_write_type q[$];
      logic [31:0]   crc_out;
      logic [7:0]    v;
      logic          done;
      done = 1'b0;
      case (op)
         OP_NAME: begin
            if (arc_state == ST_IDLE) begin
               if (entries >= ENTRY_MAX) begin add_reject(ERR_ENTRIES); return; end
               if (name_fill >= NAME_STORE) begin add_reject(ERR_NAME_FULL); return; end
               if (wr_offset > 33'h100000000 - 31) begin add_reject(ERR_RANGE); return; end
               hdr_offset = wr_offset[31:0];
               for (int i = 0; i < 30; i++) begin
                  v = i < 4 ? byte_of(SIG_LOCAL, i) : (i == 4 ? ZIP_VER : 8'd0);
                  add_write(q, wr_offset + i, v, 1'b0);
               end
               wr_offset  = wr_offset + 30;
               crc_acc    = CRC_INIT;
               data_count = '0;
               name_len   = '0;
               arc_state  = ST_NAME;
            end else if (arc_state == ST_NAME) begin
               if (name_fill >= NAME_STORE) begin add_reject(ERR_NAME_FULL); return; end
               if (name_len >= 16'hffff || wr_offset > 33'hffffffff) begin
                  add_reject(ERR_RANGE);
                  return;
               end
            end else begin
               add_reject(ERR_ORDER);
               return;
            end
            name_mem[name_fill] = b;
            name_fill = name_fill + 1;
            name_len  = name_len + 1;
            add_write(q, wr_offset, b, 1'b0);
            wr_offset = wr_offset + 1;
         end
         OP_DATA: begin
            if (arc_state == ST_IDLE) begin add_reject(ERR_NO_NAME); return; end
            if (arc_state != ST_NAME && arc_state != ST_DATA) begin
               add_reject(ERR_ORDER);
               return;
            end
            if (data_count >= 33'hffffffff || wr_offset > 33'hffffffff) begin
               add_reject(ERR_RANGE);
               return;
            end
            arc_state  = ST_DATA;
            crc_acc    = crc_next(crc_acc, b);
            data_count = data_count + 1;
            add_write(q, wr_offset, b, 1'b0);
            wr_offset = wr_offset + 1;
         end
         OP_END: begin
            if (arc_state == ST_IDLE) begin add_reject(ERR_NO_NAME); return; end
            if (arc_state != ST_NAME && arc_state != ST_DATA) begin
               add_reject(ERR_ORDER);
               return;
            end
            crc_out = ~crc_acc;
            for (int i = 0; i < 4; i++)
               add_write(q, {1'b0, hdr_offset} + 14 + i, byte_of(crc_out, i), 1'b0);
            for (int i = 0; i < 8; i++)
               add_write(q, {1'b0, hdr_offset} + 18 + i, byte_of(data_count[31:0], i), 1'b0);
            for (int i = 0; i < 2; i++)
               add_write(q, {1'b0, hdr_offset} + 26 + i, byte_of({19'd0, name_len}, i), 1'b0);
            if (entries < ENTRY_MAX) begin
               row_crc[entries]        = crc_out;
               row_size[entries]       = data_count[31:0];
               row_offset[entries]     = hdr_offset;
               row_name_start[entries] = name_fill - name_len;
               row_name_len[entries]   = name_len;
               entries = entries + 1;
            end
            crc_acc    = CRC_INIT;
            data_count = '0;
            name_len   = '0;
            arc_state  = ST_IDLE;
         end
         default: begin
            if (arc_state == ST_IDLE) begin
               if (entries == 0) begin add_reject(ERR_EMPTY); return; end
               if (wr_offset > 33'hffffffff) begin add_reject(ERR_RANGE); return; end
               cdir_start = wr_offset[31:0];
               tr_row     = '0;
               tr_byte    = '0;
               arc_state  = ST_TRAILER;
            end else if (arc_state != ST_TRAILER) begin
               add_reject(ERR_ORDER);
               return;
            end
            if (wr_offset > 33'hffffffff) begin add_reject(ERR_RANGE); return; end
            if (tr_row < entries && tr_row < ENTRY_MAX) begin
               v = cdir_byte(tr_row, tr_byte);
               tr_byte = tr_byte + 1;
               if (tr_byte >= 46 + row_name_len[tr_row]) begin
                  tr_row  = tr_row + 1;
                  tr_byte = '0;
               end
            end else begin
               v = eocd_byte(tr_byte);
               tr_byte = tr_byte + 1;
               if (tr_byte >= 22) begin
                  arc_state = ST_DONE;
                  done = 1'b1;
               end
            end
            add_write(q, wr_offset, v, done);
            wr_offset = wr_offset + 1;
         end
      endcase
      q[q.size() - 1].last = 1'b1;
      foreach (q[i]) expected_writes.insert(expected_writes.size(), q[i]);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0h, expected %0h (at %0t)", what, got, want, $realtime);
      error_count++;
   endtask

   // Sends one transaction. Push stays high after acceptance, so a following
   // transaction with no idle gap reuses it without lowering it in between.
   task automatic send_item(input logic [1:0] op, input logic [7:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push        <= 1'b1;
      req_op      <= op;
      req_byte_in <= b;
      do @(posedge clock); while (full);
      predict_archive(op, b);
   endtask

   // Holds off the sender until every expected write has been seen.
   task automatic wait_drained();
      push <= 1'b0;
      @(posedge clock);
      while (expected_writes.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = receiver_pct;
   endtask

   // A well-formed entry with random content.
   task automatic send_entry(input int n_name, input int n_data);
      for (int i = 0; i < n_name; i++) send_item(OP_NAME, 8'($urandom_range(255)));
      for (int i = 0; i < n_data; i++) send_item(OP_DATA, 8'($urandom_range(255)));
      send_item(OP_END, 8'($urandom_range(255)));
   endtask

   // Error cases on an empty archive, then field extremes and every operation.
   task automatic test_directed();
      set_idling(0, 0);
      send_item(OP_DATA, 8'hff);
      send_item(OP_END, 8'h00);
      send_item(OP_TICK, 8'hff);
      send_item(OP_NAME, 8'h00);
      send_item(OP_NAME, 8'hff);
      send_item(OP_DATA, 8'h00);
      send_item(OP_DATA, 8'hff);
      send_item(OP_NAME, 8'h5a);   // name after data is out of order
      send_item(OP_TICK, 8'h00);   // trailer while an entry is open
      send_item(OP_DATA, 8'ha5);
      send_item(OP_END, 8'hff);
      send_item(OP_NAME, 8'h41);   // entry with a name and no data
      send_item(OP_TICK, 8'h00);
      send_item(OP_END, 8'h00);
      wait_drained();
   endtask

   // Mostly well-formed entries with random content, with some noise mixed in,
   // run through each idling pattern in turn. Once the entry budget is used up,
   // an idle archive only sees rejected transactions.
   task automatic test_random_entries();
      int seg;
      int pick;
      int start_entries;
      random_items = 0;
      seg = 0;
      start_entries = entries;
      while (random_items < RANDOM_ITEMS) begin
         case (random_items * 4 / RANDOM_ITEMS)
            0: set_idling(0, 0);
            1: set_idling(77, 0);
            2: set_idling(0, 77);
            default: set_idling(35, 35);
         endcase
         pick = $urandom_range(99);
         if (pick < 12 || (arc_state == ST_IDLE &&
                           entries >= start_entries + RANDOM_ENTRIES)) begin
            // Noise: items that are out of place for the current state.
            case (arc_state)
               ST_IDLE: send_item($urandom_range(1) ? OP_DATA : OP_END,
                                  8'($urandom_range(255)));
               ST_NAME: send_item(OP_TICK, 8'($urandom_range(255)));
               default: send_item($urandom_range(1) ? OP_NAME : OP_TICK,
                                  8'($urandom_range(255)));
            endcase
            random_items++;
         end else if (pick < 20 && arc_state == ST_IDLE) begin
            // A broken entry: a name and data, closed later by a random end.
            send_item(OP_NAME, 8'($urandom_range(255)));
            send_item(OP_DATA, 8'($urandom_range(255)));
            random_items += 2;
         end else if (arc_state == ST_IDLE) begin
            int n_name;
            int n_data;
            n_name = $urandom_range(1, 6);
            n_data = $urandom_range(0, 40);
            send_entry(n_name, n_data);
            random_items += n_name + n_data + 1;
         end else begin
            send_item(OP_DATA, 8'($urandom_range(255)));
            if ($urandom_range(3) == 0) send_item(OP_END, 8'd0);
            random_items++;
         end
         if (seg != random_items * 4 / RANDOM_ITEMS) begin
            seg = random_items * 4 / RANDOM_ITEMS;
            if (seg == 2) wait_drained();
         end
      end
      if (arc_state != ST_IDLE) send_item(OP_END, 8'd0);
      wait_drained();
   endtask

   // Streams the central directory and end record, with one stray item inside
   // the trailer and a few after the archive is done.
   task automatic test_trailer();
      int n;
      n = 0;
      while (arc_state != ST_DONE) begin
         set_idling(n % 2000 < 1000 ? 35 : 0, n % 2000 < 1000 ? 35 : 77);
         send_item(OP_TICK, 8'($urandom_range(255)));
         if (n == 100) send_item(OP_NAME, 8'h7e);
         n++;
      end
      send_item(OP_TICK, 8'h00);
      send_item(OP_NAME, 8'h01);
      send_item(OP_DATA, 8'h02);
      send_item(OP_END, 8'h03);
      wait_drained();
   endtask

   // Output monitor, receiver stalls and the watchdog. Outputs are sampled at
   // the edge and pop is driven for the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (pop && !empty) begin
            if (expected_writes.size() == 0) begin
               $display("UNEXPECTED write at address %0h (at %0t)", rsp_address, $realtime);
               error_count++;
            end else begin
               arc_write_type w;
               w = expected_writes.pop_front();
               if (rsp_write_enable !== w.we)
                  report_mismatch("write_enable", rsp_write_enable, w.we);
               if (rsp_address !== w.addr) report_mismatch("address", rsp_address, w.addr);
               if (rsp_value !== w.value) report_mismatch("value", rsp_value, w.value);
               if (rsp_last !== w.last) report_mismatch("last", rsp_last, w.last);
               if (rsp_error !== w.error) report_mismatch("error", rsp_error, w.error);
               if (rsp_archive_done !== w.done)
                  report_mismatch("archive_done", rsp_archive_done, w.done);
            end
         end
         if ((pop && !empty) || (push && !full)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d writes outstanding", expected_writes.size());
            $display("** zip_stored_archive_framer: FAILED **");
            $finish;
         end
         pop <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      push = 1'b0;
      req_op = OP_NAME;
      req_byte_in = 8'd0;
      error_count = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      arc_state = ST_IDLE;
      wr_offset = '0;
      hdr_offset = '0;
      crc_acc = CRC_INIT;
      data_count = '0;
      name_len = '0;
      name_fill = '0;
      entries = '0;
      tr_row = '0;
      tr_byte = '0;
      cdir_start = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_entries();
      test_trailer();

      // Everything has drained; wait with push low so that any stray write shows
      // before the verdict.
      push <= 1'b0;
      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_writes.size() == 0) begin
         $display("** zip_stored_archive_framer: PASSED **");
      end else begin
         $display("** zip_stored_archive_framer: FAILED **");
      end
      $finish;
   end

endmodule
